/* design/ppr_pkg.sv */
// ppr_pkg: shared types, codes and constants of the poll response decoder
// used by pad_poll_response_decoder_unit; depends on nothing
package ppr_pkg;

  localparam int MAX_REPLY_BYTES_DEF = 8;
  localparam int STORED_BYTES        = 8;
  localparam int IDX_W               = $clog2(STORED_BYTES);

  localparam logic [4:0] CTRL_TYPE_ABSENT = 5'd16;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_CHANGED     = 3'd1;
  localparam logic [2:0] ST_NO_DEVICE   = 3'd2;
  localparam logic [2:0] ST_INVALID     = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  // configuration register indexes
  localparam logic CFG_PREFIX     = 1'b0;
  localparam logic CFG_MOUSE_TYPE = 1'b1;

  localparam logic [7:0] PREFIX_RST     = 8'd90;
  localparam logic [3:0] MOUSE_TYPE_RST = 4'd1;

  typedef struct packed {
    logic [2:0]        status;
    logic [4:0]        controller_type;
    logic [15:0]       button_bits;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
  } res_t;

  // analog byte to signed value, offset by 128 unless the device is a mouse
  function automatic logic signed [7:0] analog_val(input logic [7:0] b, input logic is_mouse);
    analog_val = is_mouse ? b : (b ^ 8'h80);
  endfunction

endpackage

/* design/pad_poll_response_decoder_unit.sv */
// pad_poll_response_decoder_unit: collects poll reply bytes and decodes the reply
// depends on ppr_pkg (types, status codes, constants)
// results are registered in the output register, or in the skid register while one result waits
// throughput: one request per cycle while the skid register is empty; a two-entry output stage
// (result + skid register) keeps input ready while one result waits; input stalls while the skid is full
// reset: byte count 0, previous type none, outputs empty, registers to 90 and 1
module pad_poll_response_decoder_unit #(
  parameter int MAX_REPLY_BYTES = ppr_pkg::MAX_REPLY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [7:0]        in_data_byte,
  input  logic              in_final_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [4:0]        out_controller_type,
  output logic [15:0]       out_button_bits,
  output logic signed [7:0] out_right_x,
  output logic signed [7:0] out_right_y,
  output logic signed [7:0] out_left_x,
  output logic signed [7:0] out_left_y,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata
);
  import ppr_pkg::*;

  localparam int CNT_W = $clog2(MAX_REPLY_BYTES + 1);

  logic [7:0]       prefix_r;
  logic [3:0]       mouse_type_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [4:0]       prev_type_r, prev_type_nxt;
  logic [7:0]       reply_r [STORED_BYTES];
  logic [7:0]       eff     [STORED_BYTES];

  res_t res;
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  logic in_fire, res_fire, out_take;
  logic [3:0] type_nib;
  logic is_mouse;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;
  assign res_fire = in_fire && (!in_kind || in_final_byte);

  assign cnt_inc = (cnt_r < CNT_W'(MAX_REPLY_BYTES)) ? cnt_r + CNT_W'(1) : cnt_r;

  // current byte overlays the store at the write position
  always_comb begin
    for (int j = 0; j < STORED_BYTES; j++) begin
      eff[j] = (cnt_r == CNT_W'(j)) ? in_data_byte : reply_r[j];
    end
  end

  assign type_nib = eff[0][7:4];
  assign is_mouse = (type_nib == mouse_type_r);

  always_comb begin
    res           = '0;
    res.status    = ST_OK;
    res.controller_type = CTRL_TYPE_ABSENT;
    prev_type_nxt = prev_type_r;
    cnt_nxt       = cnt_r;
    if (!in_kind) begin
      res.status    = ST_NO_DEVICE;
      prev_type_nxt = CTRL_TYPE_ABSENT;
      cnt_nxt       = '0;
    end else if (!in_final_byte) begin
      cnt_nxt = cnt_inc;
    end else begin
      cnt_nxt       = '0;
      prev_type_nxt = CTRL_TYPE_ABSENT;
      if (cnt_inc < CNT_W'(4)) begin
        res.status = ST_INVALID;
      end else if (eff[1] != prefix_r) begin
        res.status = ST_UNSUPPORTED;
      end else begin
        prev_type_nxt       = {1'b0, type_nib};
        res.controller_type = {1'b0, type_nib};
        res.status          = ({1'b0, type_nib} == prev_type_r) ? ST_OK : ST_CHANGED;
        res.button_bits     = ~{eff[3], eff[2]};
        if (cnt_inc >= CNT_W'(6)) begin
          res.right_y = analog_val(eff[4], is_mouse);
          res.right_x = analog_val(eff[5], is_mouse);
        end
        if (cnt_inc >= CNT_W'(8)) begin
          res.left_y = analog_val(eff[6], is_mouse);
          res.left_x = analog_val(eff[7], is_mouse);
        end
      end
    end
  end

  // reply byte store, no reset
  always_ff @(posedge clk) begin
    if (in_fire && in_kind && (cnt_r < CNT_W'(STORED_BYTES))) begin
      reply_r[cnt_r[IDX_W-1:0]] <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r     <= PREFIX_RST;
      mouse_type_r <= MOUSE_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PREFIX:     prefix_r     <= cfg_wdata;
        CFG_MOUSE_TYPE: mouse_type_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      prev_type_r <= CTRL_TYPE_ABSENT;
    end else if (in_fire) begin
      cnt_r       <= cnt_nxt;
      prev_type_r <= prev_type_nxt;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid_r || out_take) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_controller_type = out_r.controller_type;
  assign out_button_bits     = out_r.button_bits;
  assign out_right_x         = out_r.right_x;
  assign out_right_y         = out_r.right_y;
  assign out_left_x          = out_r.left_x;
  assign out_left_y          = out_r.left_y;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_REPLY_BYTES))
    else $error("byte count past saturation");

  a_nodev_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_kind) |=> (cnt_r == '0) && (prev_type_r == CTRL_TYPE_ABSENT))
    else $error("no-device request did not clear transaction state");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_final_byte) |=> (cnt_r == '0))
    else $error("byte count not cleared after final byte");

  a_ok_has_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == ST_OK || out_r.status == ST_CHANGED))
      |-> (out_r.controller_type != CTRL_TYPE_ABSENT))
    else $error("decoded result without a controller type");

endmodule

/* tb/ppr_decode_checker.sv */
`timescale 1ns / 1ps
// ppr_decode_checker: watches the request, result and register ports of the poll decoder,
// predicts each result from its own copy of the decoder state and compares field by field
// depends on ppr_pkg for the result struct, status codes and reset values
module ppr_decode_checker #(
  parameter int MAX_BYTES = ppr_pkg::MAX_REPLY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_kind,
  input  logic [7:0]        in_data_byte,
  input  logic              in_final_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        out_status,
  input  logic [4:0]        out_controller_type,
  input  logic [15:0]       out_button_bits,
  input  logic signed [7:0] out_right_x,
  input  logic signed [7:0] out_right_y,
  input  logic signed [7:0] out_left_x,
  input  logic signed [7:0] out_left_y,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata,
  output int                fail_count,
  output int                results_outstanding,
  output int                results_checked
);
  import ppr_pkg::*;

  int          reply_len;
  logic [7:0]  reply_mem [STORED_BYTES];
  logic [4:0]  prev_type;
  logic [7:0]  prefix_reg;
  logic [3:0]  mouse_reg;
  res_t        poll_results_due [$];
  int          mismatches = 0;
  int          checked = 0;

  // stick byte: a mouse reports raw deltas, every other device is centered on 128
  function automatic logic [7:0] stick_value(input logic [7:0] b, input logic mouse);
    return mouse ? b : b - 8'd128;
  endfunction

  // returns 1 when the request produces a result
  function automatic logic decode_request(input logic kind, input logic [7:0] data,
                                          input logic last, output res_t r);
    logic [4:0] last_type;
    logic [3:0] ty;
    logic       mouse;
    r = '0;
    r.controller_type = CTRL_TYPE_ABSENT;
    last_type = prev_type;
    if (!kind) begin
      reply_len = 0;
      prev_type = CTRL_TYPE_ABSENT;
      r.status  = ST_NO_DEVICE;
      return 1'b1;
    end
    if (reply_len < STORED_BYTES) reply_mem[IDX_W'(reply_len)] = data;
    if (reply_len < MAX_BYTES) reply_len++;
    if (!last) return 1'b0;

    prev_type = CTRL_TYPE_ABSENT;
    if (reply_len < 4) begin
      reply_len = 0;
      r.status  = ST_INVALID;
      return 1'b1;
    end
    if (reply_mem[1] != prefix_reg) begin
      reply_len = 0;
      r.status  = ST_UNSUPPORTED;
      return 1'b1;
    end

    ty = reply_mem[0][7:4];
    mouse = (ty == mouse_reg);
    prev_type = {1'b0, ty};
    r.controller_type = {1'b0, ty};
    r.button_bits = ~{reply_mem[3], reply_mem[2]};
    if (reply_len >= 6) begin
      r.right_y = stick_value(reply_mem[4], mouse);
      r.right_x = stick_value(reply_mem[5], mouse);
    end
    if (reply_len >= 8) begin
      r.left_y = stick_value(reply_mem[6], mouse);
      r.left_x = stick_value(reply_mem[7], mouse);
    end
    r.status = ({1'b0, ty} == last_type) ? ST_OK : ST_CHANGED;
    reply_len = 0;
    return 1'b1;
  endfunction

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t due;
    res_t fresh;
    if (!rst_n) begin
      reply_len  = 0;
      prev_type  = CTRL_TYPE_ABSENT;
      prefix_reg = PREFIX_RST;
      mouse_reg  = MOUSE_TYPE_RST;
      foreach (reply_mem[i]) reply_mem[i] = 8'h00;
      poll_results_due.delete();
    end else begin
      // results leave before this edge's request is decoded
      if (out_valid && out_ready) begin
        checked++;
        if (poll_results_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual status %0d type %0d",
                   $time, out_status, out_controller_type);
          mismatches++;
        end else begin
          due = poll_results_due.pop_front();
          report_field("status", due.status, out_status);
          report_field("controller_type", due.controller_type, out_controller_type);
          report_field("button_bits", due.button_bits, out_button_bits);
          report_field("right_x", due.right_x, out_right_x);
          report_field("right_y", due.right_y, out_right_y);
          report_field("left_x", due.left_x, out_left_x);
          report_field("left_y", due.left_y, out_left_y);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_PREFIX) prefix_reg = cfg_wdata;
        else mouse_reg = cfg_wdata[3:0];
      end
      if (in_valid && in_ready) begin
        if (decode_request(in_kind, in_data_byte, in_final_byte, fresh))
          poll_results_due.push_back(fresh);
      end
    end
    fail_count          <= mismatches;
    results_outstanding <= poll_results_due.size();
    results_checked     <= checked;
  end

endmodule

/* tb/tb_pad_poll_response_decoder_unit.sv */
`timescale 1ns / 1ps
// tb_pad_poll_response_decoder_unit: drives poll replies and no-device requests into the
// decoder under several register settings and gives the verdict; depends on ppr_pkg,
// pad_poll_response_decoder_unit and ppr_decode_checker
module tb_pad_poll_response_decoder_unit;
  import ppr_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_kind = 1'b0;
  logic [7:0]        in_data_byte = 8'h00;
  logic              in_final_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_status;
  logic [4:0]        out_controller_type;
  logic [15:0]       out_button_bits;
  logic signed [7:0] out_right_x;
  logic signed [7:0] out_right_y;
  logic signed [7:0] out_left_x;
  logic signed [7:0] out_left_y;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_PREFIX;
  logic [7:0]        cfg_wdata = 8'h00;

  int fail_count;
  int results_outstanding;
  int results_checked;

  logic [7:0] reply_q [$];
  logic [7:0] cur_prefix = PREFIX_RST;
  logic [3:0] cur_mouse = MOUSE_TYPE_RST;
  logic [3:0] sticky_type = 4'h0;
  logic       rx_free = 1'b0;
  logic       no_gaps = 1'b0;
  int         burst_left = 0;
  int         ready_left = 0;
  int         requests_sent = 0;
  int         polls_sent = 0;
  int         settings_used = 1;
  int         drain_cycles;

  pad_poll_response_decoder_unit dut (.*);

  ppr_decode_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: runs of stalls and runs of ready, plus random flips; always ready while rx_free is set
  always @(posedge clk) begin
    if (rx_free) begin
      out_ready <= 1'b1;
    end else if (ready_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready <= 1'b0;
          ready_left = $urandom_range(1, 8);
        end
        1, 2: begin
          out_ready <= 1'b1;
          ready_left = $urandom_range(1, 20);
        end
        default: begin
          out_ready <= 1'($urandom);
          ready_left = 1;
        end
      endcase
    end else begin
      ready_left--;
    end
  end

  // after each accepted request: end of burst brings an optional gap
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_req(input logic kind, input logic [7:0] data, input logic last);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_data_byte  <= data;
    in_final_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    if (!kind || last) polls_sent++;
    pace();
  endtask

  task automatic send_reply();
    foreach (reply_q[i]) send_req(1'b1, reply_q[i], i == reply_q.size() - 1);
  endtask

  // mostly well-formed replies with random content; some short, long, foreign, aborted or no-device
  task automatic send_random_poll();
    int r;
    int len;
    int cut;
    logic [3:0] ty;
    logic [7:0] b;
    if ($urandom_range(0, 99) < 6) begin
      send_req(1'b0, 8'($urandom), 1'($urandom));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 10) len = $urandom_range(1, 3);
    else if (r < 88) len = $urandom_range(4, 8);
    else len = $urandom_range(9, 14);
    r = $urandom_range(0, 9);
    ty = (r < 5) ? sticky_type : (r < 7) ? cur_mouse : 4'($urandom);
    sticky_type = ty;
    cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, len) : len;
    for (int i = 0; i < len; i++) begin
      if (i == cut) begin
        // device drops out mid-reply
        send_req(1'b0, 8'($urandom), 1'($urandom));
        return;
      end
      case (i)
        0: b = {ty, 4'($urandom)};
        1: b = ($urandom_range(0, 99) < 88) ? cur_prefix : 8'($urandom);
        default: b = 8'($urandom);
      endcase
      send_req(1'b1, b, i == len - 1);
    end
  endtask

  // only called with the decoder idle
  task automatic set_config(input logic [7:0] prefix, input logic [7:0] mouse_raw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PREFIX;
    cfg_wdata <= prefix;
    @(posedge clk);
    cfg_index <= CFG_MOUSE_TYPE;
    cfg_wdata <= mouse_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_prefix = prefix;
    cur_mouse  = mouse_raw[3:0];
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    drain_cycles = 0;
    while (results_outstanding != 0 && drain_cycles < 10000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [7:0] p;
    logic [7:0] m;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    send_req(1'b0, 8'hA5, 1'b0);  // no device, final flag ignored
    reply_q = '{8'hFF, 8'hFF};  // short reply
    send_reply();
    reply_q = '{8'h40, 8'h5B, 8'h00, 8'h00};  // foreign prefix
    send_reply();
    reply_q = '{8'h7F, 8'h5A, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'hC3};  // ninth byte dropped
    send_reply();
    reply_q = '{8'h70, 8'h5A, 8'hFF, 8'h00};  // same type again
    send_reply();
    reply_q = '{8'h1E, 8'h5A, 8'h55, 8'hAA, 8'h80, 8'h7F};  // mouse, raw deltas
    send_reply();
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          p = 8'h00;
          m = 8'h00;
        end
        1: begin
          p = 8'hFF;
          m = 8'h0F;
        end
        2: begin
          p = PREFIX_RST;
          m = {4'hA, MOUSE_TYPE_RST};  // upper bits must be dropped
        end
        default: begin
          p = 8'($urandom);
          m = 8'($urandom);
        end
      endcase
      set_config(p, m);
      settings_used++;
      no_gaps = (ph == 2);
      rx_free <= (ph == 2);
      sticky_type = cur_mouse;
      for (int n = requests_sent; requests_sent - n < 184; ) send_random_poll();
      wait_idle();
    end

    $display("sent %0d requests in %0d polls under %0d register settings, %0d results checked",
             requests_sent, polls_sent, settings_used, results_checked);
    if (results_outstanding != 0)
      $display("%0t ns: %0d expected results never arrived", $time, results_outstanding);
    if (fail_count == 0 && results_outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("%0t ns: run did not finish in time", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
design/ppr_pkg.sv
design/pad_poll_response_decoder_unit.sv
tb/ppr_decode_checker.sv
tb/tb_pad_poll_response_decoder_unit.sv
